[src/rwmmd_pkg.sv]
package rwmmd_pkg;

   localparam int STAT_DEPTH   = 64;
   localparam int DEMAND_DEPTH = 16;
   localparam int CHANNELS     = 6;

   localparam int CH_W  = 3;
   localparam int VAL_W = 24;

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SPOS_W   = $clog2(STAT_DEPTH);
   localparam int DPOS_W   = $clog2(DEMAND_DEPTH);
   localparam int SFILL_W  = $clog2(STAT_DEPTH + 1);
   localparam int DFILL_W  = $clog2(DEMAND_DEPTH + 1);

   localparam int SCAN_MAX = (STAT_DEPTH > DEMAND_DEPTH) ? STAT_DEPTH : DEMAND_DEPTH;
   localparam int IDX_W    = $clog2(SCAN_MAX + 1);

   localparam int SUM_W  = VAL_W + SFILL_W;
   localparam int DCNT_W = $clog2(SUM_W + 1);

   localparam int STAT_RAM_DEPTH = CHANNELS * STAT_DEPTH;
   localparam int DEM_RAM_DEPTH  = CHANNELS * DEMAND_DEPTH;
   localparam int SA_W           = $clog2(STAT_RAM_DEPTH);
   localparam int DA_W           = $clog2(DEM_RAM_DEPTH);

   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] vmin;
      logic [VAL_W-1:0] vmax;
      logic [VAL_W-1:0] vavg;
      logic [VAL_W-1:0] dem;
   } chan_result_type;

endpackage

[src/rwmmd_ram.sv]
module rwmmd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rms_window_min_max_avg_demand.sv]
// Windowed RMS statistics for six metering channels (voltage L1-L3 on channels 0-2, current
// L1-L3 on 3-5). Each request carries one channel's sample; an active request on a valid
// channel stores it in that channel's statistics ring and demand ring, then rescans both rings
// and returns min, max, truncated mean and demand. An active request passes through the write,
// scan, load, divide and finish steps; the scan covers the channel's statistics fill N (at most
// 64) and the divider runs over SUM_W = 31 quotient bits. The scan reads one entry per cycle via
// the single read port of the statistics RAM, and the mean comes from a restoring divider taking
// one quotient bit per cycle. An inactive request, or one for a channel above the last, returns
// the stored (or all-zero) statistics without a scan. One request is in work at a time; the
// next is taken while the previous result still waits on the response.
module rms_window_min_max_avg_demand (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rwmmd_pkg::CH_W-1:0]  req_channel,
   input  logic                        req_active,
   input  logic [rwmmd_pkg::VAL_W-1:0] req_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rwmmd_pkg::CH_W-1:0]  rsp_channel_out,
   output logic                        rsp_has_data,
   output logic [rwmmd_pkg::VAL_W-1:0] rsp_window_min,
   output logic [rwmmd_pkg::VAL_W-1:0] rsp_window_max,
   output logic [rwmmd_pkg::VAL_W-1:0] rsp_window_avg,
   output logic [rwmmd_pkg::VAL_W-1:0] rsp_demand
);

   import rwmmd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [CH_W-1:0]    ch_ff, ch_in;
   logic [VAL_W-1:0]   sample_ff, sample_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               stat_pend_ff, stat_pend_in;
   logic               dem_pend_ff, dem_pend_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [VAL_W-1:0]   min_ff, min_in;
   logic [VAL_W-1:0]   max_ff, max_in;
   logic [VAL_W-1:0]   dem_ff, dem_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [SFILL_W-1:0] rem_ff, rem_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;

   logic [SPOS_W-1:0]  spos_ff  [CHANNELS];
   logic [SPOS_W-1:0]  spos_in  [CHANNELS];
   logic [SFILL_W-1:0] sfill_ff [CHANNELS];
   logic [SFILL_W-1:0] sfill_in [CHANNELS];
   logic [DPOS_W-1:0]  dpos_ff  [CHANNELS];
   logic [DPOS_W-1:0]  dpos_in  [CHANNELS];
   logic [DFILL_W-1:0] dfill_ff [CHANNELS];
   logic [DFILL_W-1:0] dfill_in [CHANNELS];
   chan_result_type    res_ff   [CHANNELS];
   chan_result_type    res_in   [CHANNELS];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]    rsp_ch_ff, rsp_ch_in;
   chan_result_type    rsp_res_ff, rsp_res_in;

   logic [CH_IDX_W-1:0] ch_idx;
   logic                ch_ok;
   logic                req_ch_ok;
   logic [SFILL_W-1:0]  sn;
   logic [DFILL_W-1:0]  dn;
   logic [SA_W-1:0]     stat_base;
   logic [DA_W-1:0]     dem_base;

   logic               stat_wr_en, stat_rd_en;
   logic [SA_W-1:0]    stat_wr_addr, stat_rd_addr;
   logic [VAL_W-1:0]   stat_rd_data;
   logic               dem_wr_en, dem_rd_en;
   logic [DA_W-1:0]    dem_wr_addr, dem_rd_addr;
   logic [VAL_W-1:0]   dem_rd_data;

   logic [SFILL_W:0]   div_shift;
   logic [SFILL_W:0]   div_diff;
   logic               div_bit;

   assign ch_idx    = CH_IDX_W'(ch_ff);
   assign ch_ok     = 32'(ch_ff) < CHANNELS;
   assign req_ch_ok = 32'(req_channel) < CHANNELS;
   assign sn        = sfill_ff[ch_idx];
   assign dn        = dfill_ff[ch_idx];
   assign stat_base = SA_W'(ch_idx) * SA_W'(STAT_DEPTH);
   assign dem_base  = DA_W'(ch_idx) * DA_W'(DEMAND_DEPTH);

   assign stat_wr_en   = state_ff == ST_WRITE;
   assign stat_wr_addr = stat_base + SA_W'(spos_ff[ch_idx]);
   assign stat_rd_en   = (state_ff == ST_SCAN) && (idx_ff < IDX_W'(sn));
   assign stat_rd_addr = stat_base + SA_W'(idx_ff);

   assign dem_wr_en    = state_ff == ST_WRITE;
   assign dem_wr_addr  = dem_base + DA_W'(dpos_ff[ch_idx]);
   assign dem_rd_en    = (state_ff == ST_SCAN) && (idx_ff < IDX_W'(dn));
   assign dem_rd_addr  = dem_base + DA_W'(idx_ff);

   rwmmd_ram #(.WIDTH(VAL_W), .DEPTH(STAT_RAM_DEPTH)) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_wr_en),
      .wr_addr (stat_wr_addr),
      .wr_data (sample_ff),
      .rd_en   (stat_rd_en),
      .rd_addr (stat_rd_addr),
      .rd_data (stat_rd_data)
   );

   rwmmd_ram #(.WIDTH(VAL_W), .DEPTH(DEM_RAM_DEPTH)) u_dem_ram (
      .clock   (clock),
      .wr_en   (dem_wr_en),
      .wr_addr (dem_wr_addr),
      .wr_data (sample_ff),
      .rd_en   (dem_rd_en),
      .rd_addr (dem_rd_addr),
      .rd_data (dem_rd_data)
   );

   // restoring divide step; remainder stays below the fill count
   assign div_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign div_diff  = div_shift - (SFILL_W+1)'(sn);
   assign div_bit   = div_shift >= (SFILL_W+1)'(sn);

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      sample_in    = sample_ff;
      idx_in       = idx_ff;
      stat_pend_in = 1'b0;
      dem_pend_in  = 1'b0;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      dem_in       = dem_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      spos_in      = spos_ff;
      sfill_in     = sfill_ff;
      dpos_in      = dpos_ff;
      dfill_in     = dfill_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_res_in   = rsp_res_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // read data lands in the cycle after the scan issues the address
      if (stat_pend_ff) begin
         sum_in = sum_ff + SUM_W'(stat_rd_data);
         if (stat_rd_data < min_ff) begin
            min_in = stat_rd_data;
         end
         if (stat_rd_data > max_ff) begin
            max_in = stat_rd_data;
         end
      end
      if (dem_pend_ff && (dem_rd_data > dem_ff)) begin
         dem_in = dem_rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ch_in     = req_channel;
               sample_in = req_sample;
               state_in  = (req_active && req_ch_ok) ? ST_WRITE : ST_FINISH;
            end
         end
         ST_WRITE: begin
            spos_in[ch_idx] = (32'(spos_ff[ch_idx]) == STAT_DEPTH - 1) ? '0
                                                                       : spos_ff[ch_idx] + 1'b1;
            dpos_in[ch_idx] = (32'(dpos_ff[ch_idx]) == DEMAND_DEPTH - 1) ? '0
                                                                         : dpos_ff[ch_idx] + 1'b1;
            if (32'(sfill_ff[ch_idx]) < STAT_DEPTH) begin
               sfill_in[ch_idx] = sfill_ff[ch_idx] + 1'b1;
            end
            if (32'(dfill_ff[ch_idx]) < DEMAND_DEPTH) begin
               dfill_in[ch_idx] = dfill_ff[ch_idx] + 1'b1;
            end
            idx_in   = '0;
            sum_in   = '0;
            min_in   = '1;
            max_in   = '0;
            dem_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            stat_pend_in = stat_rd_en;
            dem_pend_in  = dem_rd_en;
            if (stat_rd_en || dem_rd_en) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            quo_in   = sum_ff;
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = div_bit ? div_diff[SFILL_W-1:0] : div_shift[SFILL_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], div_bit};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(SUM_W - 1)) begin
               res_in[ch_idx] = '{valid: 1'b1, vmin: min_ff, vmax: max_ff,
                                  vavg: quo_in[VAL_W-1:0], dem: dem_ff};
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               rsp_res_in   = ch_ok ? res_ff[ch_idx] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_ch_ff    <= '0;
         rsp_res_ff   <= '0;
         stat_pend_ff <= 1'b0;
         dem_pend_ff  <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            spos_ff[c]  <= '0;
            sfill_ff[c] <= '0;
            dpos_ff[c]  <= '0;
            dfill_ff[c] <= '0;
            res_ff[c]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ch_ff    <= rsp_ch_in;
         rsp_res_ff   <= rsp_res_in;
         stat_pend_ff <= stat_pend_in;
         dem_pend_ff  <= dem_pend_in;
         spos_ff      <= spos_in;
         sfill_ff     <= sfill_in;
         dpos_ff      <= dpos_in;
         dfill_ff     <= dfill_in;
         res_ff       <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      sample_ff  <= sample_in;
      idx_ff     <= idx_in;
      sum_ff     <= sum_in;
      min_ff     <= min_in;
      max_ff     <= max_in;
      dem_ff     <= dem_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      dcnt_ff    <= dcnt_in;
   end

   assign req_ready       = state_ff == ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_ch_ff;
   assign rsp_has_data    = rsp_res_ff.valid;
   assign rsp_window_min  = rsp_res_ff.vmin;
   assign rsp_window_max  = rsp_res_ff.vmax;
   assign rsp_window_avg  = rsp_res_ff.vavg;
   assign rsp_demand      = rsp_res_ff.dem;

endmodule

[src/rwmmd_checker.sv]
module rwmmd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rwmmd_pkg::CH_W-1:0]  rsp_channel_out,
   input logic                        rsp_has_data,
   input logic [rwmmd_pkg::VAL_W-1:0] rsp_window_min,
   input logic [rwmmd_pkg::VAL_W-1:0] rsp_window_max,
   input logic [rwmmd_pkg::VAL_W-1:0] rsp_window_avg,
   input logic [rwmmd_pkg::VAL_W-1:0] rsp_demand
);

   import rwmmd_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_out)
         && $stable(rsp_has_data) && $stable(rsp_window_min) && $stable(rsp_window_max)
         && $stable(rsp_window_avg) && $stable(rsp_demand))
      else $error("response changed while stalled");

   // channels past the last never report statistics
   a_bad_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (32'(rsp_channel_out) >= CHANNELS) |-> !rsp_has_data)
      else $error("statistics reported for nonexistent channel");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_data |-> rsp_window_min == '0 && rsp_window_max == '0
         && rsp_window_avg == '0 && rsp_demand == '0)
      else $error("empty channel reported nonzero values");

   // truncated mean lies between min and max
   a_avg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_data |-> rsp_window_min <= rsp_window_avg
         && rsp_window_avg <= rsp_window_max)
      else $error("mean outside min/max range");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind rms_window_min_max_avg_demand rwmmd_checker u_rwmmd_checker (.*);

[tb/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rwmmd_pkg::*;

   typedef struct {
      logic [CH_W-1:0] channel;
      chan_result_type stats;
   } meter_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CH_W-1:0]     req_channel;
   logic                req_active;
   logic [VAL_W-1:0]    req_sample;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [CH_W-1:0]     rsp_channel_out;
   logic                rsp_has_data;
   logic [VAL_W-1:0]    rsp_window_min;
   logic [VAL_W-1:0]    rsp_window_max;
   logic [VAL_W-1:0]    rsp_window_avg;
   logic [VAL_W-1:0]    rsp_demand;

   // predictor state, one set per channel
   logic [VAL_W-1:0]    stat_ring [CHANNELS][STAT_DEPTH];
   logic [VAL_W-1:0]    dem_ring  [CHANNELS][DEMAND_DEPTH];
   int                  stat_pos  [CHANNELS];
   int                  stat_cnt  [CHANNELS];
   int                  dem_pos   [CHANNELS];
   int                  dem_cnt   [CHANNELS];
   chan_result_type     held_stats [CHANNELS];

   meter_result_type    expected_q [$];

   int                  error_count   = 0;
   int                  sent_count    = 0;
   int                  active_count  = 0;
   int                  checked_count = 0;
   int                  send_gap_max  = 18;
   int                  rsp_gap_max   = 18;
   int                  rsp_hold_cycles = 0;

   rms_window_min_max_avg_demand uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_channel     (req_channel),
      .req_active      (req_active),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_channel_out (rsp_channel_out),
      .rsp_has_data    (rsp_has_data),
      .rsp_window_min  (rsp_window_min),
      .rsp_window_max  (rsp_window_max),
      .rsp_window_avg  (rsp_window_avg),
      .rsp_demand      (rsp_demand)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic meter_result_type predict_stats(logic [CH_W-1:0] ch, logic act,
                                                      logic [VAL_W-1:0] value);
      meter_result_type r;
      logic [VAL_W-1:0] lo;
      logic [VAL_W-1:0] hi;
      logic [63:0]      total;
      int               c;
      int               i;
      r.channel = ch;
      r.stats   = '0;
      if (ch >= CHANNELS) return r;
      c = int'(ch);
      if (act) begin
         stat_ring[c][stat_pos[c]] = value;
         stat_pos[c] = (stat_pos[c] + 1) % STAT_DEPTH;
         if (stat_cnt[c] < STAT_DEPTH) stat_cnt[c]++;
         lo    = stat_ring[c][0];
         hi    = lo;
         total = '0;
         for (i = 0; i < stat_cnt[c]; i++) begin
            total += 64'(stat_ring[c][i]);
            if (stat_ring[c][i] < lo) lo = stat_ring[c][i];
            if (stat_ring[c][i] > hi) hi = stat_ring[c][i];
         end
         held_stats[c].valid = 1'b1;
         held_stats[c].vmin  = lo;
         held_stats[c].vmax  = hi;
         held_stats[c].vavg  = VAL_W'(total / 64'(stat_cnt[c]));

         dem_ring[c][dem_pos[c]] = value;
         dem_pos[c] = (dem_pos[c] + 1) % DEMAND_DEPTH;
         if (dem_cnt[c] < DEMAND_DEPTH) dem_cnt[c]++;
         hi = dem_ring[c][0];
         for (i = 1; i < dem_cnt[c]; i++)
            if (dem_ring[c][i] > hi) hi = dem_ring[c][i];
         held_stats[c].dem = hi;
      end
      r.stats = held_stats[c];
      return r;
   endfunction

   // mostly real channels, now and then one of the unused codes
   function automatic logic [CH_W-1:0] pick_channel();
      if ($urandom_range(15, 0) < 14) return CH_W'($urandom_range(CHANNELS - 1, 0));
      return CH_W'($urandom_range((1 << CH_W) - 1, CHANNELS));
   endfunction

   function automatic logic [VAL_W-1:0] pick_sample();
      case ($urandom_range(4, 0))
         0: return VAL_W'($urandom_range(255, 0));
         1: return {16'hFFFF, 8'($urandom_range(255, 0))};
         2: return $urandom_range(1, 0) ? '1 : '0;
         default: return VAL_W'($urandom());
      endcase
   endfunction

   function automatic void match_field(string field, logic [VAL_W-1:0] want,
                                       logic [VAL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   task automatic send_req(input logic [CH_W-1:0] ch, input logic act,
                           input logic [VAL_W-1:0] value);
      int gap;
      gap = $urandom_range(send_gap_max, 0);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_active  <= act;
      req_sample  <= value;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(predict_stats(ch, act, value));
      sent_count++;
      if (act) active_count++;
   endtask

   // drop valid and wait for every outstanding result
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_idle_report();
      int ch;
      for (ch = 0; ch < (1 << CH_W); ch++)
         send_req(CH_W'(ch), 1'b0, pick_sample());
      wait_drained();
   endtask

   task automatic test_sample_extremes();
      send_req(0, 1'b1, '0);
      send_req(0, 1'b1, '1);
      send_req(0, 1'b1, 24'h800000);
      send_req(0, 1'b0, 24'h123456);
      send_req(1, 1'b1, '1);
      send_req(1, 1'b1, '1);
      send_req(6, 1'b1, '1);
      send_req(7, 1'b1, 24'h123456);
      send_req(2, 1'b1, 24'hAAAAAA);
      send_req(3, 1'b1, 24'h555555);
      send_req(4, 1'b1, 24'hAAAAAA);
      send_req(5, 1'b1, 24'h555555);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count);
      int n;
      send_gap_max = 18;
      rsp_gap_max  = 18;
      for (n = 0; n < count; n++)
         send_req(pick_channel(), $urandom_range(7, 0) != 0, pick_sample());
      wait_drained();
   endtask

   task automatic test_streaming(input int count);
      int n;
      send_gap_max = 0;
      rsp_gap_max  = 0;
      for (n = 0; n < count; n++)
         send_req(pick_channel(), $urandom_range(9, 0) != 0, pick_sample());
      wait_drained();
   endtask

   // receiver stalls long enough for the input side to back up
   task automatic test_backpressure();
      int n;
      send_gap_max    = 0;
      rsp_gap_max     = 3;
      rsp_hold_cycles = 400;
      for (n = 0; n < 60; n++)
         send_req(pick_channel(), $urandom_range(3, 0) != 0, pick_sample());
      wait_drained();
      send_gap_max = 12;
      for (n = 0; n < 40; n++)
         send_req(pick_channel(), 1'b1, pick_sample());
      wait_drained();
   endtask

   // rising and falling runs push old extremes out of both windows
   task automatic test_ramps(input int count);
      int              n;
      int              i;
      int              len;
      int              start;
      int              step;
      int              v;
      bit              up;
      logic [CH_W-1:0] ch;
      send_gap_max = 6;
      rsp_gap_max  = 6;
      n = 0;
      while (n < count) begin
         ch    = CH_W'($urandom_range(CHANNELS - 1, 0));
         len   = $urandom_range(80, 5);
         start = $urandom_range(24'hFFFFFF, 0);
         step  = $urandom_range(4095, 0);
         up    = 1'($urandom_range(1, 0));
         for (i = 0; i < len && n < count; i++) begin
            v = up ? start + i * step : start - i * step;
            if (v > 24'hFFFFFF) v = 24'hFFFFFF;
            if (v < 0) v = 0;
            if ($urandom_range(19, 0) == 0)
               send_req(pick_channel(), 1'($urandom_range(1, 0)), pick_sample());
            else
               send_req(ch, $urandom_range(24, 0) != 0, v[VAL_W-1:0]);
            n++;
         end
      end
      wait_drained();
   endtask

   initial begin
      int c;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_channel = '0;
      req_active  = 1'b0;
      req_sample  = '0;
      for (c = 0; c < CHANNELS; c++) begin
         stat_pos[c]   = 0;
         stat_cnt[c]   = 0;
         dem_pos[c]    = 0;
         dem_cnt[c]    = 0;
         held_stats[c] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_report();
      test_sample_extremes();
      test_random_traffic(700);
      test_streaming(400);
      test_backpressure();
      test_ramps(730);

      repeat (120) @(posedge clock);
      $display("Covered %0d requests (%0d active) on all channel codes, %0d results checked,",
               sent_count, active_count, checked_count);
      $display("including window wraparound, idle channels, stalls and back-to-back traffic.");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // response side: random ready gaps plus an occasional long hold
   initial begin
      int wait_n;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         wait_n = $urandom_range(rsp_gap_max, 0) + rsp_hold_cycles;
         rsp_hold_cycles = 0;
         if (wait_n > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      meter_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual channel %0d",
                     $time, rsp_channel_out);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            checked_count++;
            match_field("channel_out", VAL_W'(want.channel), VAL_W'(rsp_channel_out));
            match_field("has_data", VAL_W'(want.stats.valid), VAL_W'(rsp_has_data));
            match_field("window_min",  want.stats.vmin,  rsp_window_min);
            match_field("window_max",  want.stats.vmax,  rsp_window_max);
            match_field("window_avg",  want.stats.vavg,  rsp_window_avg);
            match_field("demand",      want.stats.dem,   rsp_demand);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d results outstanding", expected_q.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
src/rwmmd_pkg.sv
src/rwmmd_ram.sv
src/rms_window_min_max_avg_demand.sv
src/rwmmd_checker.sv
tb/testbench.sv
